### design/tlvf_pkg.sv
// Shared types, constants and helpers of the text line view filter.
// Used by the front, the queue, the back and the top level.
`timescale 1ns / 1ps

package tlvf_pkg;

  // Width of the printed line number, in decimal digits
  localparam int NumDigits = 6;
  // Digits that take part in counting: the number saturates at 999999
  localparam int CapDigits = (NumDigits < 6) ? NumDigits : 6;
  localparam int DigitW = 4;

  // Output positions of one item: digits, tab, prefix byte, final byte
  localparam int PosW = $clog2(NumDigits + 3);
  localparam logic [PosW-1:0] PosFirst = '0;
  localparam logic [PosW-1:0] PosTab = PosW'(NumDigits);
  localparam logic [PosW-1:0] PosPre = PosW'(NumDigits + 1);
  localparam logic [PosW-1:0] PosFin = PosW'(NumDigits + 2);

  // Queue between front and back
  localparam int QDepth = 4;
  localparam int QPtrW = $clog2(QDepth);

  // Configuration register indexes
  localparam int CfgIdxW = 3;
  localparam logic [CfgIdxW-1:0] RegNumberAll = 3'd0;
  localparam logic [CfgIdxW-1:0] RegNumberNonblank = 3'd1;
  localparam logic [CfgIdxW-1:0] RegSqueezeBlank = 3'd2;
  localparam logic [CfgIdxW-1:0] RegShowLineEnds = 3'd3;
  localparam logic [CfgIdxW-1:0] RegShowTabs = 3'd4;
  localparam logic [CfgIdxW-1:0] RegShowNonprinting = 3'd5;

  // Characters
  localparam logic [7:0] CharTab = 8'h09;
  localparam logic [7:0] CharNewline = 8'h0A;
  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharDollar = 8'h24;
  localparam logic [7:0] CharZero = 8'h30;
  localparam logic [7:0] CharUpperI = 8'h49;
  localparam logic [7:0] CharCaret = 8'h5E;
  localparam logic [7:0] CharCtrlLimit = 8'h20;
  localparam logic [7:0] CtrlOffset = 8'd64;

  // Line number as packed BCD, index 0 the least significant digit
  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;
  localparam digits_t DigitsOne = digits_t'(1);

  typedef struct packed {
    logic number_all_lines;
    logic number_nonblank;
    logic squeeze_blank;
    logic show_line_ends;
    logic show_tabs;
    logic show_nonprinting;
  } cfg_t;

  // One classified item waiting for output
  typedef struct packed {
    logic       num_en;
    digits_t    digits;
    logic       pre_en;
    logic [7:0] pre_byte;
    logic [7:0] fin_byte;
  } q_entry_t;

  // Queue status toward the front
  typedef struct packed {
    logic             full;
    logic             not_empty;
    logic [QPtrW:0]   count;
  } q_stat_t;

  // Increment the BCD line number, holding at the cap
  function automatic digits_t bcd_inc(digits_t d);
    digits_t r;
    logic    carry;
    logic    sat;
    r = d;
    carry = 1'b1;
    sat = 1'b1;
    for (int k = 0; k < CapDigits; k++) begin
      if (d[k] != DigitW'(9)) sat = 1'b0;
    end
    for (int k = 0; k < CapDigits; k++) begin
      if (carry) begin
        if (r[k] == DigitW'(9)) begin
          r[k] = '0;
        end else begin
          r[k] = r[k] + DigitW'(1);
          carry = 1'b0;
        end
      end
    end
    if (sat) r = d;
    return r;
  endfunction

endpackage

### design/tlvf_front.sv
// Front of the text line view filter: accepts input bytes, tracks line state
// and the line number, and pushes one classified entry per output-producing byte.
// Depends on tlvf_pkg.
`timescale 1ns / 1ps

module tlvf_front import tlvf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] text_byte
  input  logic       s_tuser,   // [0] file_start
  input  q_stat_t    q_stat,
  output logic       push,
  output q_entry_t   entry
);

  logic       at_line_start;
  logic [1:0] blank_run;
  digits_t    line_counter;

  logic       accept;
  logic       newline;
  logic       is_tab;
  logic       is_ctrl;
  logic       squeeze_hit;
  logic [1:0] blank_run_next;
  logic       suppress;
  logic       want_num;
  logic       num_en;
  digits_t    counter_cur;
  digits_t    line_counter_next;

  assign s_tready = !q_stat.full;
  assign accept = s_tvalid && s_tready;

  // Classify the byte
  always_comb begin
    newline = (s_tdata == CharNewline);
    is_tab = (s_tdata == CharTab);
    is_ctrl = (s_tdata < CharTab) || (s_tdata > CharNewline && s_tdata < CharCtrlLimit);

    squeeze_hit = cfg.squeeze_blank && newline && at_line_start;
    if (squeeze_hit) begin
      blank_run_next = (blank_run == 2'd3) ? 2'd3 : blank_run + 2'd1;
    end else begin
      blank_run_next = 2'd0;
    end
    suppress = squeeze_hit && (blank_run_next > 2'd1);

    want_num = cfg.number_nonblank ? !newline : cfg.number_all_lines;
    num_en = want_num && at_line_start && !suppress;

    counter_cur = s_tuser ? DigitsOne : line_counter;
    line_counter_next = num_en ? bcd_inc(counter_cur) : counter_cur;
  end

  // Build the entry for the back
  always_comb begin
    entry.num_en = num_en;
    entry.digits = counter_cur;
    entry.pre_en = 1'b0;
    entry.pre_byte = CharCaret;
    entry.fin_byte = s_tdata;
    if (cfg.show_tabs && is_tab) begin
      entry.pre_en = 1'b1;
      entry.fin_byte = CharUpperI;
    end else if (cfg.show_line_ends && newline) begin
      entry.pre_en = 1'b1;
      entry.pre_byte = CharDollar;
    end else if (cfg.show_nonprinting && is_ctrl) begin
      entry.pre_en = 1'b1;
      entry.fin_byte = s_tdata + CtrlOffset;
    end
  end

  // Squeezed lines give no output and are dropped here
  assign push = accept && !suppress;

  // Advance line state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      at_line_start <= 1'b1;
      blank_run <= 2'd0;
      line_counter <= DigitsOne;
    end else if (accept) begin
      at_line_start <= newline;
      blank_run <= blank_run_next;
      line_counter <= line_counter_next;
    end
  end

endmodule

### design/tlvf_queue.sv
// Short queue of classified entries between front and back.
// Depends on tlvf_pkg.
`timescale 1ns / 1ps

module tlvf_queue import tlvf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  q_entry_t push_entry,
  input  logic     pop,
  output q_entry_t head,
  output q_stat_t  stat
);

  q_entry_t         mem [QDepth];
  logic [QPtrW-1:0] wr_ptr;
  logic [QPtrW-1:0] rd_ptr;
  logic [QPtrW:0]   count;
  logic             do_push;
  logic             do_pop;

  assign stat.full = (count == (QPtrW + 1)'(QDepth));
  assign stat.not_empty = (count != '0);
  assign stat.count = count;
  assign do_push = push && !stat.full;
  assign do_pop = pop && stat.not_empty;
  assign head = mem[rd_ptr];

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_entry;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + QPtrW'(1);
      if (do_pop) rd_ptr <= rd_ptr + QPtrW'(1);
      case ({do_push, do_pop})
        2'b10:   count <= count + (QPtrW + 1)'(1);
        2'b01:   count <= count - (QPtrW + 1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### design/tlvf_back.sv
// Back of the text line view filter: walks the head entry of the queue one
// output byte per cycle unless the output stalls, and drives the registered output stream.
// Depends on tlvf_pkg.
`timescale 1ns / 1ps

module tlvf_back import tlvf_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  q_entry_t   head,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] out_byte
  output logic       m_tlast    // last_of_run
);

  logic              started;
  logic [PosW-1:0]   pos;
  logic [PosW-1:0]   start_pos;
  logic [PosW-1:0]   cur_pos;
  logic [PosW-1:0]   next_pos;
  logic              load;
  logic              is_last;
  logic [NumDigits:0] nz_above;
  logic [7:0]        cur_byte;

  assign load = q_stat.not_empty && (!m_tvalid || m_tready);

  // Pick the position of the next byte
  always_comb begin
    if (head.num_en) start_pos = PosFirst;
    else if (head.pre_en) start_pos = PosPre;
    else start_pos = PosFin;
    cur_pos = started ? pos : start_pos;
    is_last = (cur_pos == PosFin);
    if (cur_pos == PosTab) next_pos = head.pre_en ? PosPre : PosFin;
    else next_pos = cur_pos + PosW'(1);
  end

  // Mark digits with a nonzero digit at or above them
  always_comb begin
    nz_above[NumDigits] = 1'b0;
    for (int k = NumDigits - 1; k >= 0; k--) begin
      nz_above[k] = nz_above[k + 1] || (head.digits[k] != '0);
    end
  end

  // Select the byte at the current position
  always_comb begin
    cur_byte = head.fin_byte;
    if (cur_pos == PosTab) begin
      cur_byte = CharTab;
    end else if (cur_pos == PosPre) begin
      cur_byte = head.pre_byte;
    end else if (cur_pos != PosFin) begin
      cur_byte = CharSpace;
      for (int k = 0; k < NumDigits; k++) begin
        if (cur_pos == PosW'(NumDigits - 1 - k)) begin
          if (nz_above[k] || k == 0) cur_byte = CharZero + {4'd0, head.digits[k]};
          else cur_byte = CharSpace;
        end
      end
    end
  end

  assign pop = load && is_last;

  // Step through the entry
  always_ff @(posedge clk) begin
    if (rst) begin
      started <= 1'b0;
      pos <= PosFirst;
    end else if (load) begin
      started <= !is_last;
      pos <= next_pos;
    end
  end

  // Hold the output byte until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= cur_byte;
      m_tlast <= is_last;
    end
  end

endmodule

### design/text_line_view_filter_top.sv
// Top level of the text line view filter: configuration registers, front,
// queue and back. Depends on tlvf_pkg, tlvf_front, tlvf_queue and tlvf_back.
`timescale 1ns / 1ps

// Rewrites a text byte stream the way the display options of cat do:
// squeezes repeated blank lines, numbers lines as a six-wide right-aligned
// decimal and a tab, shows tabs as ^I, marks line ends with $ and shows
// control bytes as caret pairs. Bytes 127 and above pass unchanged.
// Input: s_tvalid/s_tready/s_tdata carry the text byte, s_tuser marks the
// first byte of a file (line number back to 1).
// Output: m_tvalid/m_tready/m_tdata carry one output byte, m_tlast marks the
// last byte caused by one input byte. A squeezed newline gives no output.
// Configuration: cfg_we writes bit 0 of cfg_data into register cfg_index
// (0 number all, 1 number nonblank, 2 squeeze, 3 line ends, 4 tabs,
// 5 nonprinting); write only while the block is idle.
// An input byte reaches the output through the queue and then the output register.
// Throughput: the back emits one byte per cycle while m_tready is high, and an
// input byte produces 0 to 9 output bytes (none for a squeezed newline);
// the front takes one byte per cycle while the four-entry queue has room.
// Reset clears the configuration, the queue and the output register; the
// line number goes to 1. When m_tready is low the output byte holds, the
// queue fills and s_tready drops once it is full.
module text_line_view_filter_top import tlvf_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] text_byte
  input  logic               s_tuser,   // [0] file_start
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [7:0]         m_tdata,   // [7:0] out_byte
  output logic               m_tlast,   // last_of_run
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [0:0]         cfg_data
);

  cfg_t     cfg;
  q_stat_t  q_stat;
  q_entry_t push_entry;
  q_entry_t head;
  logic     q_push;
  logic     q_pop;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        RegNumberAll:       cfg.number_all_lines <= cfg_data[0];
        RegNumberNonblank:  cfg.number_nonblank <= cfg_data[0];
        RegSqueezeBlank:    cfg.squeeze_blank <= cfg_data[0];
        RegShowLineEnds:    cfg.show_line_ends <= cfg_data[0];
        RegShowTabs:        cfg.show_tabs <= cfg_data[0];
        RegShowNonprinting: cfg.show_nonprinting <= cfg_data[0];
        default:            cfg <= cfg;
      endcase
    end
  end

  tlvf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .q_stat   (q_stat),
    .push     (q_push),
    .entry    (push_entry)
  );

  tlvf_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .head       (head),
    .stat       (q_stat)
  );

  tlvf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .head     (head),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Queue never holds more than its depth
  a_q_bound: assert property (@(posedge clk) disable iff (rst)
    q_stat.count <= (QPtrW + 1)'(QDepth))
    else $error("queue count beyond depth");

  // Output register is empty after reset
  a_out_reset: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  // A stalled output byte blocks the back from retiring an entry
  a_stall_no_pop: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !q_pop)
    else $error("entry retired while output stalled");

endmodule
